### hdl/hsd_pkg.sv
// Shared constants and decode functions for the Hamming (31,26) stream decoder.
// Depends on nothing; imported by hamming_31_26_stream_decoder_top.
package hsd_pkg;

    localparam int CW_BITS    = 31;
    localparam int DATA_BITS  = 26;
    localparam int SYN_BITS   = 5;
    localparam int COUNT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // XOR of every codeword position (1..31) that holds a one
    function automatic logic [SYN_BITS-1:0] cw_syndrome(input logic [CW_BITS-1:0] cw);
        logic [SYN_BITS-1:0] syn;
        syn = '0;
        for (int p = 1; p <= CW_BITS; p++) begin
            if (cw[CW_BITS-p])
                syn = syn ^ SYN_BITS'(p);
        end
        return syn;
    endfunction

    // Drop the parity positions 1, 2, 4, 8 and 16; keep data in position order
    function automatic logic [DATA_BITS-1:0] cw_data(input logic [CW_BITS-1:0] cw);
        logic [DATA_BITS-1:0] d;
        int k;
        d = '0;
        k = 0;
        for (int p = 1; p <= CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                d[DATA_BITS-1-k] = cw[CW_BITS-p];
                k = k + 1;
            end
        end
        return d;
    endfunction

endpackage

### hdl/hamming_31_26_stream_decoder_top.sv
// Hamming (31,26) stream decoder: byte input, codeword assembly, correction,
// byte packing and per-message count report. Depends on hsd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one encoded byte per transaction,
//   MSB first, with end_of_message set on the last byte of a message.
//   Output channel (out_valid/out_ready) carries decoded bytes (byte_valid=1)
//   and, after the last byte of a message, one count report (byte_valid=0,
//   out_byte=0). last_result marks the final result caused by an input byte.
//   corrected_count is the saturating number of corrected codewords so far.
// Path: an input byte is registered in the input stage, then decoded in one pass
//   into a batch register that drives out_valid.
// Throughput: one input byte per cycle unless the input stage waits (below). The
//   batch register emits one result per cycle while out_ready is high. Bytes
//   that complete nothing pass a pending batch; a byte that completes a
//   codeword or ends a message waits in the input stage until the last result
//   of the previous batch is accepted.
// Reset: clears all codeword, packer and count state and empties both stages.
// Stall: while out_ready is low the batch holds; once a byte that needs the
//   batch reaches the input stage, in_ready drops until the batch drains.
module hamming_31_26_stream_decoder_top
    import hsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_message,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic [COUNT_BITS-1:0] corrected_count,
    output logic                  last_result
);

    // input stage
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_eom_reg;

    // decode state
    logic [CW_BITS-1:0]    cw_reg, cw_next;
    logic [4:0]            fill_reg, fill_next;
    logic [6:0]            pk_reg, pk_next;
    logic [2:0]            pk_fill_reg, pk_fill_next;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;

    // result batch
    logic                  b_valid_reg;
    logic [7:0]            b_bytes_reg [4];
    logic [2:0]            b_num_reg;
    logic [2:0]            b_last_reg;
    logic [2:0]            b_pos_reg;
    logic [COUNT_BITS-1:0] b_tally_reg;

    logic                  b_free;
    logic                  a_adv;
    logic                  b_load;
    logic                  complete;
    logic [38:0]           ext;
    logic [2:0]            shamt;
    logic [CW_BITS-1:0]    full_cw;
    logic [CW_BITS-1:0]    fixed_cw;
    logic [SYN_BITS-1:0]   syn;
    logic [4:0]            flip_pos;
    logic [5:0]            total_bits;
    logic [32:0]           pack;
    logic [32:0]           aligned;
    logic [2:0]            num_data;
    logic [COUNT_BITS-1:0] tally_upd;

    // handshake: only bytes that load the batch wait for it
    assign b_free   = !b_valid_reg || (out_ready && (b_pos_reg == b_last_reg));
    assign a_adv    = a_valid_reg && (b_free || !(complete || a_eom_reg));
    assign in_ready = !a_valid_reg || a_adv;

    // assemble codeword from held bits and the new byte
    assign ext      = {cw_reg, a_byte_reg};
    assign complete = (fill_reg >= 5'd23);
    assign shamt    = 3'(fill_reg - 5'd23);
    assign full_cw  = CW_BITS'(ext >> shamt);

    // syndrome and single-bit correction
    assign syn      = cw_syndrome(full_cw);
    assign flip_pos = 5'(CW_BITS) - syn;
    assign fixed_cw = (syn != '0) ? (full_cw ^ (CW_BITS'(1) << flip_pos)) : full_cw;
    assign tally_upd = ((syn != '0) && (tally_reg != COUNT_MAX)) ? tally_reg + 1'b1
                                                                  : tally_reg;

    // pack leftover bits with the new data bits, left-align to cut bytes
    assign pack       = {pk_reg, cw_data(fixed_cw)};
    assign total_bits = {3'b000, pk_fill_reg} + 6'(DATA_BITS);
    assign aligned    = pack << (6'd33 - total_bits);
    assign num_data   = complete ? total_bits[5:3] : 3'd0;
    assign b_load     = a_adv && (complete || a_eom_reg);

    // next decode state
    always_comb
    begin
        cw_next      = ext[CW_BITS-1:0];
        fill_next    = fill_reg + 5'd8;
        pk_next      = pk_reg;
        pk_fill_next = pk_fill_reg;
        tally_next   = tally_reg;
        if (complete)
        begin
            cw_next      = CW_BITS'(a_byte_reg & ((8'd1 << shamt) - 8'd1));
            fill_next    = {2'b00, shamt};
            pk_next      = pack[6:0];
            pk_fill_next = total_bits[2:0];
            tally_next   = tally_upd;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_byte_reg <= data_byte;
            a_eom_reg  <= end_of_message;
        end
    end

    // advance decode state; clear it at end of message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg      <= '0;
            fill_reg    <= '0;
            pk_reg      <= '0;
            pk_fill_reg <= '0;
            tally_reg   <= '0;
        end
        else if (a_adv)
        begin
            if (a_eom_reg)
            begin
                cw_reg      <= '0;
                fill_reg    <= '0;
                pk_reg      <= '0;
                pk_fill_reg <= '0;
                tally_reg   <= '0;
            end
            else
            begin
                cw_reg      <= cw_next;
                fill_reg    <= fill_next;
                pk_reg      <= pk_next;
                pk_fill_reg <= pk_fill_next;
                tally_reg   <= tally_next;
            end
        end
    end

    // batch control: load, step through results, drop when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_pos_reg   <= '0;
            b_num_reg   <= '0;
            b_last_reg  <= '0;
        end
        else if (b_load)
        begin
            b_valid_reg <= 1'b1;
            b_pos_reg   <= '0;
            b_num_reg   <= num_data;
            b_last_reg  <= a_eom_reg ? num_data : (num_data - 3'd1);
        end
        else if (b_free)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            b_pos_reg <= b_pos_reg + 3'd1;
        end
    end

    // batch payload
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                b_bytes_reg[k] <= aligned[32-8*k -: 8];
            end
            b_tally_reg <= complete ? tally_upd : tally_reg;
        end
    end

    // result outputs
    assign out_valid       = b_valid_reg;
    assign byte_valid      = (b_pos_reg < b_num_reg);
    assign out_byte        = byte_valid ? b_bytes_reg[b_pos_reg[1:0]] : 8'd0;
    assign corrected_count = b_tally_reg;
    assign last_result     = (b_pos_reg == b_last_reg);

`ifndef SYNTHESIS
    // a count report always closes the results of its input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> last_result)
        else $error("count report is not the last result");

    // the count stays fixed across the results of one batch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_result) |=> $stable(corrected_count))
        else $error("corrected_count changed inside a batch");

    // the batch is never reloaded while it still has results
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> !b_load)
        else $error("batch reloaded while results are pending");

    // a batch never holds more than four data bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (b_num_reg <= 3'd4) && (b_pos_reg <= b_last_reg))
        else $error("batch index out of range");
`endif

endmodule

### dv/hamming_scoreboard_pkg.sv
// Scoreboard for the Hamming (31,26) stream decoder: predicts the decoded bytes
// and count reports of each input transaction and checks each output transaction.
// Depends on hsd_pkg for the width of the correction count.
package hamming_scoreboard_pkg;

    import hsd_pkg::COUNT_BITS;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic [COUNT_BITS-1:0] corrected_count;
        logic                  last_result;
    } decoded_result_t;

    // XOR of the positions (1..31) that hold a one; position 1 is the MSB
    function automatic logic [4:0] position_xor(input logic [30:0] cw);
        logic [4:0] acc;
        acc = '0;
        for (int p = 1; p <= 31; p++)
        begin
            if (cw[31-p])
                acc = acc ^ 5'(p);
        end
        return acc;
    endfunction

    class hamming_scoreboard;

        logic [30:0]           cw_bits;
        int                    cw_fill;
        logic [7:0]            pack_bits;
        int                    pack_fill;
        logic [COUNT_BITS-1:0] tally;
        decoded_result_t       expected_results[$];
        decoded_result_t       batch[$];
        int                    errors;

        function new();
            clear_message();
            errors = 0;
        endfunction

        function void clear_message();
            cw_bits   = '0;
            cw_fill   = 0;
            pack_bits = '0;
            pack_fill = 0;
            tally     = '0;
        endfunction

        function void emit(input logic [7:0] value, input logic is_data);
            decoded_result_t r;
            r.out_byte        = value;
            r.byte_valid      = is_data;
            r.corrected_count = tally;
            r.last_result     = 1'b0;
            batch.push_back(r);
        endfunction

        // Shift one accepted byte in and queue every result it causes
        function void note_byte(input logic [7:0] data, input logic eom);
            logic [4:0]      syn;
            decoded_result_t r;
            batch.delete();
            for (int i = 7; i >= 0; i--)
            begin
                cw_bits = {cw_bits[29:0], data[i]};
                cw_fill++;
                if (cw_fill == 31)
                begin
                    // flip the position named by the syndrome and count it
                    syn = position_xor(cw_bits);
                    if (syn != 5'd0)
                    begin
                        cw_bits[31-int'(syn)] = ~cw_bits[31-int'(syn)];
                        if (tally != '1)
                            tally++;
                    end
                    // pack the data positions, skip the powers of two
                    for (int p = 1; p <= 31; p++)
                    begin
                        if ((p & (p - 1)) != 0)
                        begin
                            pack_bits = {pack_bits[6:0], cw_bits[31-p]};
                            pack_fill++;
                            if (pack_fill == 8)
                            begin
                                emit(pack_bits, 1'b1);
                                pack_fill = 0;
                            end
                        end
                    end
                    cw_bits = '0;
                    cw_fill = 0;
                end
            end
            // end of message: report the tally, drop remainders
            if (eom)
            begin
                emit(8'h00, 1'b0);
                clear_message();
            end
            foreach (batch[k])
            begin
                r = batch[k];
                r.last_result = (k == batch.size() - 1);
                expected_results.push_back(r);
            end
        endfunction

        function void check_result(input decoded_result_t got);
            decoded_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result byte=%02h valid=%b count=%0d last=%b",
                         $time, got.out_byte, got.byte_valid, got.corrected_count,
                         got.last_result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch, expected byte=%02h valid=%b count=%0d last=%b",
                             $time, want.out_byte, want.byte_valid, want.corrected_count,
                             want.last_result);
                    $display("%0t:           actual   byte=%02h valid=%b count=%0d last=%b",
                             $time, got.out_byte, got.byte_valid, got.corrected_count,
                             got.last_result);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

### dv/tb_top.sv
// Testbench top for hamming_31_26_stream_decoder_top: drives directed and random
// encoded messages under varied idling and checks every output transaction.
// Depends on hsd_pkg and hamming_scoreboard_pkg.
module tb_top;

    import hsd_pkg::*;
    import hamming_scoreboard_pkg::*;

    localparam int STALL_CYCLES = 200;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  end_of_message;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic [COUNT_BITS-1:0] corrected_count;
    logic                  last_result;

    hamming_scoreboard decoder_model;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                accepted_bytes;
    int                quiet_cycles = 0;
    bit                hold_request;

    hamming_31_26_stream_decoder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .end_of_message  (end_of_message),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .corrected_count (corrected_count),
        .last_result     (last_result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random backpressure, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each output transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            decoder_model.check_result({out_byte, byte_valid, corrected_count, last_result});
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Build a codeword with zero syndrome from 26 data bits
    function automatic logic [30:0] hamming_encode(input logic [25:0] d);
        logic [30:0] cw;
        logic [4:0]  syn;
        int          k;
        cw = '0;
        k  = 25;
        for (int p = 1; p <= 31; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                cw[31-p] = d[k];
                k--;
            end
        end
        syn = position_xor(cw);
        for (int i = 0; i < 5; i++)
        begin
            if (syn[i])
                cw[31-(1<<i)] = 1'b1;
        end
        return cw;
    endfunction

    // Offer one byte, hold it until accepted, return at the next falling edge
    task automatic send_item(input logic [7:0] value, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= value;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ready);
        decoder_model.note_byte(value, eom);
        accepted_bytes++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoder_model.pending() != 0)
            @(negedge clk);
    endtask

    // One message: mostly encoded codewords with 0, 1 or 2 flips, else raw noise
    task automatic send_message();
        bit          stream[$];
        logic [7:0]  msg[$];
        logic [30:0] cw;
        logic [7:0]  b;
        int          kind;
        int          pos_a;
        int          pos_b;
        if ($urandom_range(0, 99) < 80)
        begin
            repeat ($urandom_range(1, 6))
            begin
                cw   = hamming_encode(26'($urandom));
                kind = $urandom_range(0, 9);
                if (kind >= 4)
                begin
                    pos_a     = $urandom_range(0, 30);
                    cw[pos_a] = ~cw[pos_a];
                end
                if (kind == 9)
                begin
                    pos_b     = (pos_a + $urandom_range(1, 30)) % 31;
                    cw[pos_b] = ~cw[pos_b];
                end
                for (int i = 30; i >= 0; i--)
                    stream.push_back(cw[i]);
            end
            // pad to a byte boundary, sometimes leave a trailing remainder
            while (stream.size() % 8 != 0)
                stream.push_back(1'($urandom));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(8, 24))
                    stream.push_back(1'($urandom));
            while (stream.size() % 8 != 0)
                stream.push_back(1'($urandom));
            for (int i = 0; i < stream.size(); i += 8)
            begin
                for (int j = 0; j < 8; j++)
                    b = {b[6:0], 1'(stream[i+j])};
                msg.push_back(b);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                msg.push_back(8'($urandom));
        end
        foreach (msg[k])
            send_item(msg[k], k == msg.size() - 1);
    endtask

    initial
    begin
        decoder_model  = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        end_of_message = 1'b0;
        hold_request   = 1'b0;
        accepted_bytes = 0;
        send_idle_pct  = 23;
        recv_idle_pct  = 87;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty message: count report only
        send_item(8'h00, 1'b1);
        // all-ones codeword, zero syndrome, ends on the completing byte
        send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b1);
        // flip at position 31, then a second codeword with a flip at position 2
        send_item(8'h00, 1'b0); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);
        send_item(8'h02, 1'b0); send_item(8'h80, 1'b0); send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0); send_item(8'h00, 1'b1);
        // mixed patterns across codeword boundaries, partial byte dropped
        send_item(8'hA5, 1'b0); send_item(8'h5A, 1'b0); send_item(8'hC3, 1'b0);
        send_item(8'h3C, 1'b0); send_item(8'h0F, 1'b0); send_item(8'hF0, 1'b0);
        send_item(8'h01, 1'b0); send_item(8'hFE, 1'b1);

        // busy sender, heavy backpressure
        while (accepted_bytes < 150)
            send_message();

        // slow sender, mostly ready receiver
        send_idle_pct = 87;
        recv_idle_pct = 23;
        while (accepted_bytes < 290)
            send_message();

        // no idling; long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        while (accepted_bytes < 350)
            send_message();
        wait_drained();
        while (accepted_bytes < 420)
            send_message();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (decoder_model.errors == 0 && decoder_model.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
